// ===== design/ssmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Subarray sum match counter package
// Shared widths, payload types and datapath control types.
// ----------------------------------------------------------------------------
`default_nettype none

package ssmc_pkg;

  localparam int unsigned WINDOW_DEPTH = 16384;
  localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned LEN_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int unsigned VALUE_W  = 15;
  localparam int unsigned TARGET_W = 29;
  localparam int unsigned SUM_W    = TARGET_W + 1;
  localparam int unsigned COUNT_W  = 32;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic REG_TARGET_SUM = 1'b0;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               window_overflow;
  } out_item_t;

  typedef struct packed {
    logic               sub;
    logic [VALUE_W-1:0] operand;
  } alu_op_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } alu_flag_t;

endpackage : ssmc_pkg

`default_nettype wire

// ===== design/subarray_sum_match_counter.sv =====
// Steps per item: accept and add in idle; when the store is full, first read and
// evict its oldest element, then push. The check step removes oldest elements
// through the shared sum unit while the sum exceeds the target; the result of a
// last item is in the output register at the end of its check step, which waits
// while a result stalls. The input stalls outside idle, so items never overlap.
// Reset clears all sequence state and sets target_sum to 1; the store is not cleared.
// ----------------------------------------------------------------------------
// Subarray sum match counter
// Per sequence, counts the values that end a contiguous run summing to a target.
// ----------------------------------------------------------------------------
`default_nettype none

module subarray_sum_match_counter
  import ssmc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVICT = 3'd1;
  localparam logic [2:0] S_PUSH  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WINDOW_DEPTH);

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [COUNT_W-1:0]  matches_q, matches_d;
  logic                ovf_q, ovf_d;
  logic [TARGET_W-1:0] target_q;
  in_item_t            item_q, item_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic                in_accept;
  logic                cfg_write;
  logic                ram_we;
  logic                ram_re;
  logic [VALUE_W-1:0]  ram_rdata;
  logic [VALUE_W-1:0]  push_value;
  alu_op_t             alu_op;
  alu_flag_t           alu_flag;
  logic [SUM_W-1:0]    alu_sum;
  logic                window_full;
  logic                need_pop;
  logic                out_busy;
  logic                finish;
  logic [COUNT_W-1:0]  matches_next;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
  endfunction

  assign in_stall_o = state_q != S_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign window_full = len_q == LEN_FULL;
  assign need_pop    = alu_flag.gt && (len_q != '0);
  assign out_busy    = out_valid_q && out_stall_i;
  assign finish      = (state_q == S_CHECK) && !need_pop && !(item_q.last && out_busy);

  assign matches_next = (alu_flag.eq && (matches_q != '1)) ? matches_q + COUNT_W'(1)
                                                           : matches_q;

  assign push_value = (state_q == S_IDLE) ? in_data_i.value : item_q.value;

  ssmc_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(push_value),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  ssmc_alu u_alu (
    .sum_i   (sum_q),
    .op_i    (alu_op),
    .target_i(target_q),
    .sum_o   (alu_sum),
    .flag_o  (alu_flag)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    len_d       = len_q;
    sum_d       = sum_q;
    matches_d   = matches_q;
    ovf_d       = ovf_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    alu_op.sub     = 1'b0;
    alu_op.operand = push_value;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          item_d = in_data_i;
          if (window_full) begin
            ovf_d   = 1'b1;
            ram_re  = 1'b1;
            state_d = S_EVICT;
          end else begin
            ram_we  = 1'b1;
            sum_d   = alu_sum;
            tail_d  = next_slot(tail_q);
            len_d   = len_q + LEN_W'(1);
            state_d = S_CHECK;
          end
        end
      end
      S_EVICT: begin
        alu_op.sub     = 1'b1;
        alu_op.operand = ram_rdata;
        sum_d          = alu_sum;
        head_d         = next_slot(head_q);
        len_d          = len_q - LEN_W'(1);
        state_d        = S_PUSH;
      end
      S_PUSH: begin
        ram_we  = 1'b1;
        sum_d   = alu_sum;
        tail_d  = next_slot(tail_q);
        len_d   = len_q + LEN_W'(1);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (need_pop) begin
          ram_re  = 1'b1;
          state_d = S_POP;
        end else if (finish) begin
          state_d = S_IDLE;
          if (item_q.last) begin
            out_valid_d                = 1'b1;
            out_data_d.match_count     = matches_next;
            out_data_d.window_overflow = ovf_q;
            head_d    = '0;
            tail_d    = '0;
            len_d     = '0;
            sum_d     = '0;
            matches_d = '0;
            ovf_d     = 1'b0;
          end else begin
            matches_d = matches_next;
          end
        end
      end
      S_POP: begin
        alu_op.sub     = 1'b1;
        alu_op.operand = ram_rdata;
        sum_d          = alu_sum;
        head_d         = next_slot(head_q);
        len_d          = len_q - LEN_W'(1);
        state_d        = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      matches_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      matches_q   <= matches_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TARGET_SUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_write) begin
      target_q <= pwdata[TARGET_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TARGET_SUM) ? APB_DATA_W'(target_q) : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LEN_FULL)
    else $error("Window length exceeds the store depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (len_q != '0))
    else $error("Removal from an empty window.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && item_q.last) |=> (len_q == '0 && sum_q == '0 && out_valid_q))
    else $error("Sequence state not cleared after the result transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVICT) |-> (ovf_q && $past(window_full)))
    else $error("Eviction without a full window.");

endmodule : subarray_sum_match_counter

`default_nettype wire

// ===== design/ssmc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : ssmc_ram

`default_nettype wire

// ===== design/ssmc_alu.sv =====
// ----------------------------------------------------------------------------
// Running sum unit
// Shared add/subtract of the running sum and its compare against the target.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmc_alu
  import ssmc_pkg::*;
(
  input  wire logic [SUM_W-1:0]    sum_i,
  input  wire alu_op_t             op_i,
  input  wire logic [TARGET_W-1:0] target_i,
  output logic      [SUM_W-1:0]    sum_o,
  output alu_flag_t                flag_o
);

  logic [SUM_W-1:0] operand_ext;
  logic [SUM_W-1:0] target_ext;

  assign operand_ext = SUM_W'(op_i.operand);
  assign target_ext  = SUM_W'(target_i);

  assign sum_o     = op_i.sub ? (sum_i - operand_ext) : (sum_i + operand_ext);
  assign flag_o.gt = sum_i > target_ext;
  assign flag_o.eq = sum_i == target_ext;

endmodule : ssmc_alu

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subarray sum match counter testbench
// Streams sequences of values through the counter under several target
// settings and compares each end-of-sequence count and overflow flag with a
// local model of the sliding window. Both sides idle and stall at random, and
// one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import ssmc_pkg::*;

  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 1500000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned IDLE_PCT      = 24;

  localparam logic [APB_ADDR_W-1:0] TARGET_ADDR = APB_ADDR_W'(4 * REG_TARGET_SUM);
  localparam logic [TARGET_W-1:0]   TARGET_MAX  = '1;

  class match_tally;
    logic [TARGET_W-1:0] goal;
    logic [VALUE_W-1:0]  live_window[$];
    longint unsigned     run_sum;
    logic [COUNT_W-1:0]  match_cnt;
    logic                overflow_seen;
    out_item_t           tallies_due[$];
    int unsigned         item_cnt;
    int unsigned         result_cnt;
    int unsigned         hit_cnt;
    int unsigned         spill_cnt;
    int unsigned         error_cnt;

    function new();
      goal       = TARGET_RESET;
      item_cnt   = 0;
      result_cnt = 0;
      hit_cnt    = 0;
      spill_cnt  = 0;
      error_cnt  = 0;
      clear_run();
    endfunction

    function void clear_run();
      live_window.delete();
      run_sum       = 0;
      match_cnt     = '0;
      overflow_seen = 1'b0;
    endfunction

    function void absorb_value(in_item_t it);
      out_item_t tally_out;
      item_cnt++;
      if (live_window.size() >= WINDOW_DEPTH) begin
        overflow_seen = 1'b1;
        run_sum -= live_window.pop_front();
      end
      live_window.push_back(it.value);
      run_sum += it.value;
      while (run_sum > goal && live_window.size() > 0) begin
        run_sum -= live_window.pop_front();
      end
      if (run_sum == goal && match_cnt != '1) begin
        match_cnt++;
      end
      if (it.last) begin
        tally_out.match_count     = match_cnt;
        tally_out.window_overflow = overflow_seen;
        tallies_due.push_back(tally_out);
        clear_run();
      end
    endfunction

    function void check_tally(out_item_t got);
      out_item_t want;
      if (tallies_due.size() == 0) begin
        error_cnt++;
        $error("Unexpected result transaction: match_count %0d, window_overflow %0b",
               got.match_count, got.window_overflow);
        return;
      end
      want = tallies_due.pop_front();
      result_cnt++;
      if (got.match_count !== want.match_count) begin
        error_cnt++;
        $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
      end
      if (got.window_overflow !== want.window_overflow) begin
        error_cnt++;
        $error("window_overflow: expected %0b, got %0b",
               want.window_overflow, got.window_overflow);
      end
      if (want.match_count != 0) hit_cnt++;
      if (want.window_overflow) spill_cnt++;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  match_tally  tally;
  bit          quiet;
  bit          hold_req;
  int unsigned cycle_count;

  subarray_sum_match_counter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic in_item_t mk_item(input logic [VALUE_W-1:0] v, input logic l);
    in_item_t it;
    it.value = v;
    it.last  = l;
    return it;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input int unsigned vmax);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 18) return VALUE_W'($urandom);
    return VALUE_W'($urandom_range(vmax, 1));
  endfunction

  task automatic send(input in_item_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tally.absorb_value(it);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (tally.tallies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_target(input logic [TARGET_W-1:0] goal);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= APB_DATA_W'(goal);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tally.goal = goal;
  endtask

  task automatic run_phase(input logic [TARGET_W-1:0] goal, input int unsigned vmax,
                           input int unsigned maxlen, input int unsigned nitems);
    int unsigned sent;
    int unsigned len;
    set_target(goal);
    sent = 0;
    while (sent < nitems) begin
      len = $urandom_range(maxlen, 1);
      for (int unsigned i = 0; i < len; i++) begin
        send(mk_item(pick_value(vmax), i == len - 1));
      end
      sent += len;
    end
  endtask

  initial begin : cycle_guard
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : result_side
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) tally.check_tally(out_data_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int unsigned goal;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    tally      = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset target of one is still in force here.
    send(mk_item(VALUE_W'(1), 1'b1));
    send(mk_item('0, 1'b0));
    send(mk_item(VALUE_W'(1), 1'b0));
    send(mk_item('0, 1'b1));
    send(mk_item('1, 1'b0));
    send(mk_item(VALUE_W'(2), 1'b1));
    send(mk_item(VALUE_W'(30000), 1'b1));

    set_target('0);
    send(mk_item('0, 1'b0));
    send(mk_item(VALUE_W'(5), 1'b0));
    send(mk_item(VALUE_W'(15'h5555), 1'b0));
    send(mk_item(VALUE_W'(15'h2AAA), 1'b1));

    set_target(TARGET_MAX);
    send(mk_item('1, 1'b0));
    send(mk_item('1, 1'b0));
    send(mk_item('1, 1'b0));
    send(mk_item('1, 1'b1));

    set_target(TARGET_W'(30000));
    send(mk_item(VALUE_W'(10000), 1'b0));
    send(mk_item(VALUE_W'(20000), 1'b0));
    send(mk_item(VALUE_W'(30000), 1'b0));
    send(mk_item(VALUE_W'(1), 1'b1));

    run_phase(TARGET_W'(12), 6, 12, 150);
    run_phase('0, 5, 8, 60);
    run_phase(TARGET_MAX, 32767, 30, 120);
    run_phase(TARGET_W'(300000000), 30000, 20, 100);

    quiet = 1'b1;
    goal  = $urandom_range(2000, 20);
    run_phase(TARGET_W'(goal), goal / 3 + 1, 20, 250);
    quiet = 1'b0;

    settle_block();
    hold_req = 1'b1;
    run_phase(TARGET_W'(5), 3, 3, 150);

    while (tally.item_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(1)) begin
        goal = $urandom_range(400, 1);
        run_phase(TARGET_W'(goal), goal / 3 + 1, 16, 150);
      end else begin
        goal = $urandom_range(200000, 1000);
        run_phase(TARGET_W'(goal), 30000, 24, 150);
      end
    end

    run_phase(TARGET_W'(7), 4, 10, 60);

    settle_block();
    $display("Checked %0d results over %0d values: %0d with matches, %0d with overflow.",
             tally.result_cnt, tally.item_cnt, tally.hit_cnt, tally.spill_cnt);
    $display("Targets spanned zero to the register maximum, with one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (tally.error_cnt == 0 && tally.tallies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
